FILE: hdl/ght_pkg.sv
package ght_pkg;

  localparam int unsigned SLOT_W   = 16;
  localparam int unsigned OBJ_W    = 32;
  localparam int unsigned GEN_W    = 32;
  localparam int unsigned FLAG_W   = 8;
  localparam int unsigned OUT_W    = 10;

  localparam logic [OBJ_W-1:0] EMPTY_OBJECT = 32'hFFFF_FFFF;

  localparam logic [1:0] OP_INSERT  = 2'd0;
  localparam logic [1:0] OP_RESOLVE = 2'd1;
  localparam logic [1:0] OP_CLOSE   = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_REFUSED = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [OBJ_W-1:0]  object_index;
    logic [FLAG_W-1:0] flags_in;
    logic [SLOT_W-1:0] handle_slot;
    logic [GEN_W-1:0]  handle_generation;
  } in_word_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [OUT_W-1:0]  slot_out;
    logic [GEN_W-1:0]  generation_out;
    logic [OBJ_W-1:0]  object_out;
    logic [FLAG_W-1:0] flags_out;
    logic [OUT_W-1:0]  live_count;
  } out_word_t;

  typedef enum logic {
    CTL_IDLE,
    CTL_EXEC
  } ctl_state_e;

  typedef struct packed {
    logic capture;
    logic commit;
  } ght_cmd_t;

endpackage

FILE: hdl/generational_handle_table.sv
// Generational handle table: a fixed table of TABLE_SLOTS slots (slot 0 is
// reserved) handing out slot/generation handles from a LIFO free list. Each
// word on the input carries one operation (insert, resolve or close) and
// yields exactly one result word. The table entry is read from the
// single-port entry memory when the word is taken; in the execute state it
// is checked, written back and the free head updated, and only then is a
// further word taken, so a new word is never accepted before the last one
// has finished (the execute state is held while the result register is held
// by output stall). No clearing pass runs after reset: a high-water mark tracks
// which slots have ever been written, and slots at or above it read as empty with
// generation one and an ascending free link, so the table is usable from the
// first cycle out of reset.
module generational_handle_table #(
  parameter int unsigned TABLE_SLOTS = 1024
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  ght_pkg::in_word_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output ght_pkg::out_word_t out_word_o
);
  import ght_pkg::*;

  // commands from the sequencer to the table datapath
  ght_cmd_t cmd;

  // sequence capture, commit and the result handshake
  ght_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  // hold the entry memory, free head, high-water mark and live count
  ght_datapath #(
    .TABLE_SLOTS (TABLE_SLOTS)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .in_word_i  (in_word_i),
    .out_word_o (out_word_o)
  );

endmodule

FILE: hdl/ght_ctrl.sv
module ght_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output ght_pkg::ght_cmd_t cmd_o
);
  import ght_pkg::*;

  ctl_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= CTL_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    cmd_o.capture = 1'b0;
    cmd_o.commit  = 1'b0;
    out_valid_d   = out_valid_q && out_stall_i;
    in_stall_o    = 1'b1;
    unique case (state_q)
      CTL_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = CTL_EXEC;
        end
      end
      CTL_EXEC: begin
        // hold until the output register is free
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.commit = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = CTL_IDLE;
        end
      end
      default: state_d = CTL_IDLE;
    endcase
  end

  assign out_valid_o = out_valid_q;

  a_no_back_to_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("two words accepted in consecutive cycles");

  a_commit_after_capture: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |-> $past(cmd_o.capture) || $past(state_q == CTL_EXEC))
    else $error("commit without a captured word");

endmodule

FILE: hdl/ght_datapath.sv
module ght_datapath #(
  parameter int unsigned TABLE_SLOTS = 1024
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ght_pkg::ght_cmd_t  cmd_i,
  input  ght_pkg::in_word_t  in_word_i,
  output ght_pkg::out_word_t out_word_o
);
  import ght_pkg::*;

  localparam int unsigned AW = $clog2(TABLE_SLOTS);
  localparam logic [AW:0]     SLOTS_A = (AW + 1)'(TABLE_SLOTS);
  localparam logic [SLOT_W:0] SLOTS_S = (SLOT_W + 1)'(TABLE_SLOTS);

  typedef struct packed {
    logic [AW-1:0]     link;
    logic [FLAG_W-1:0] flags;
    logic [GEN_W-1:0]  gen;
    logic [OBJ_W-1:0]  obj;
  } entry_t;

  entry_t mem [TABLE_SLOTS];

  // captured word
  logic [1:0]        op_q;
  logic [OBJ_W-1:0]  obj_q;
  logic [FLAG_W-1:0] flg_q;
  logic [SLOT_W-1:0] hslot_q;
  logic [GEN_W-1:0]  hgen_q;
  logic [AW-1:0]     addr_q;
  entry_t            rdata_q;

  // table control
  logic [AW-1:0] head_q, head_d;
  logic [AW:0]   hwm_q, hwm_d;
  logic [AW-1:0] cnt_q, cnt_d;

  logic [AW-1:0] rd_addr;
  logic          wr_en;
  entry_t        wr_entry;
  entry_t        cur;
  entry_t        rst_entry;
  logic [AW:0]   addr_p1;
  logic          touched;
  logic          in_range;
  logic          live;
  out_word_t     out_q, out_d;
  logic [AW+OUT_W-1:0] slot_ext;
  logic [AW+OUT_W-1:0] cnt_ext;

  assign rd_addr = (in_word_i.opcode == OP_INSERT) ? head_q : in_word_i.handle_slot[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q    <= in_word_i.opcode;
      obj_q   <= in_word_i.object_index;
      flg_q   <= in_word_i.flags_in;
      hslot_q <= in_word_i.handle_slot;
      hgen_q  <= in_word_i.handle_generation;
      addr_q  <= rd_addr;
      rdata_q <= mem[rd_addr];
    end
    if (wr_en) begin
      mem[addr_q] <= wr_entry;
    end
    if (cmd_i.commit) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= AW'(1);
      hwm_q  <= (AW + 1)'(1);
      cnt_q  <= '0;
    end else begin
      head_q <= head_d;
      hwm_q  <= hwm_d;
      cnt_q  <= cnt_d;
    end
  end

  // Entries at or above the high-water mark were never written: read them as reset.
  assign addr_p1  = {1'b0, addr_q} + (AW + 1)'(1);
  assign touched  = (addr_q != '0) && ({1'b0, addr_q} < hwm_q);
  assign in_range = {1'b0, hslot_q} < SLOTS_S;

  always_comb begin
    rst_entry.link  = (addr_p1 < SLOTS_A) ? addr_p1[AW-1:0] : '0;
    rst_entry.flags = '0;
    rst_entry.gen   = GEN_W'(1);
    rst_entry.obj   = EMPTY_OBJECT;
    cur             = touched ? rdata_q : rst_entry;
  end

  assign live     = cur.obj != EMPTY_OBJECT;
  assign slot_ext = {{OUT_W{1'b0}}, addr_q};
  assign cnt_ext  = {{OUT_W{1'b0}}, cnt_d};

  always_comb begin
    head_d   = head_q;
    hwm_d    = hwm_q;
    cnt_d    = cnt_q;
    wr_en    = 1'b0;
    wr_entry = cur;
    out_d.status         = ST_INVALID;
    out_d.slot_out       = '0;
    out_d.generation_out = '0;
    out_d.object_out     = '0;
    out_d.flags_out      = '0;
    unique case (op_q)
      OP_INSERT: begin
        if (obj_q == EMPTY_OBJECT || head_q == '0) begin
          out_d.status = ST_REFUSED;
        end else begin
          wr_en          = cmd_i.commit;
          wr_entry.link  = '0;
          wr_entry.flags = flg_q;
          wr_entry.gen   = cur.gen;
          wr_entry.obj   = obj_q;
          if (cmd_i.commit) begin
            head_d = cur.link;
            cnt_d  = cnt_q + AW'(1);
            if ({1'b0, addr_q} == hwm_q) begin
              hwm_d = hwm_q + (AW + 1)'(1);
            end
          end
          out_d.status         = ST_OK;
          out_d.slot_out       = slot_ext[OUT_W-1:0];
          out_d.generation_out = cur.gen;
          out_d.flags_out      = flg_q;
        end
      end
      OP_RESOLVE: begin
        if (in_range && live && cur.gen == hgen_q) begin
          out_d.status     = ST_OK;
          out_d.object_out = cur.obj;
          out_d.flags_out  = cur.flags;
        end
      end
      OP_CLOSE: begin
        if (in_range && live) begin
          wr_en          = cmd_i.commit;
          wr_entry.link  = head_q;
          wr_entry.flags = '0;
          wr_entry.gen   = cur.gen + GEN_W'(1);
          wr_entry.obj   = EMPTY_OBJECT;
          if (cmd_i.commit) begin
            head_d = addr_q;
            if (cnt_q != '0) begin
              cnt_d = cnt_q - AW'(1);
            end
          end
          out_d.status = ST_OK;
        end
      end
      default: out_d.status = ST_INVALID;
    endcase
    out_d.live_count = cnt_ext[OUT_W-1:0];
  end

  assign out_word_o = out_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, cnt_q} < SLOTS_A)
    else $error("live count beyond table capacity");

  a_head_below_mark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (head_q != '0) |-> ({1'b0, head_q} <= hwm_q))
    else $error("free head above high-water mark");

  a_empty_list_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (head_q == '0) |-> (hwm_q == SLOTS_A))
    else $error("free list empty with untouched slots left");

endmodule
